// ===== design/npm_pkg.sv =====
// shared types and constants for the naive pattern match stream block
// used by npm_front, npm_queue, npm_back and the top level; no dependencies
package npm_pkg;

  localparam int PATTERN_MAX   = 32;
  localparam int PIDX_BITS     = $clog2(PATTERN_MAX);
  localparam int LEN_BITS      = 6;
  localparam int POSITION_BITS = 32;
  localparam int RESULT_BITS   = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = QPTR_BITS + 1;

  // op codes on the input tuser
  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [1:0] {
    KIND_PATTERN,
    KIND_TEXT,
    KIND_RESTART
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           byte_value;
    logic [PIDX_BITS-1:0] pattern_index;
  } item_t;

  // queue to back end handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ===== design/npm_front.sv =====
// front end: takes requests off the input stream and classifies them
// depends on npm_pkg
module npm_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // byte_value [7:0], pattern_index [12:8]
  input  logic [1:0]           s_tuser,   // op [1:0]
  input  logic                 queue_full,
  output logic                 push,
  output npm_pkg::item_t       push_item
);

  logic accept;

  assign s_tready = ~queue_full;
  assign accept   = s_tvalid & s_tready;

  // unused op code is taken and dropped here
  always_comb begin
    push_item.byte_value    = s_tdata[7:0];
    push_item.pattern_index = s_tdata[8 +: npm_pkg::PIDX_BITS];
    push_item.kind          = npm_pkg::KIND_TEXT;
    push                    = 1'b0;
    unique case (s_tuser)
      npm_pkg::OP_PATTERN: begin
        push_item.kind = npm_pkg::KIND_PATTERN;
        push           = accept;
      end
      npm_pkg::OP_TEXT: begin
        push_item.kind = npm_pkg::KIND_TEXT;
        push           = accept;
      end
      npm_pkg::OP_RESTART: begin
        push_item.kind = npm_pkg::KIND_RESTART;
        push           = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/npm_queue.sv =====
// short queue between the front end and the back end
// depends on npm_pkg
module npm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  npm_pkg::item_t      push_item,
  output logic                full,
  input  logic                pop,
  output npm_pkg::queue_out_t head
);

  npm_pkg::item_t                   entries [npm_pkg::QUEUE_DEPTH];
  logic [npm_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [npm_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [npm_pkg::QCNT_BITS-1:0]    count;
  logic                             do_pop;

  assign full       = (count == npm_pkg::QCNT_BITS'(npm_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/npm_back.sv =====
// back end: pattern store, text window, window compare, match counter, output register
// depends on npm_pkg
module npm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_data,
  input  npm_pkg::queue_out_t  head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // match_start [31:0], match_number [63:32]
  output logic [0:0]           m_tuser    // position_saturated [0]
);

  localparam int PM = npm_pkg::PATTERN_MAX;
  localparam int LB = npm_pkg::LEN_BITS;
  localparam int PB = npm_pkg::POSITION_BITS;
  localparam int RB = npm_pkg::RESULT_BITS;

  logic [7:0]          pattern [PM];
  logic [7:0]          window  [PM];
  logic [7:0]          window_next [PM];
  logic [PB-1:0]       position;
  logic [PB-1:0]       position_next;
  logic [LB-1:0]       pattern_length;
  logic [LB-1:0]       len_act;
  logic [LB-1:0]       shift_amt;
  logic [8*PM-1:0]     pattern_rev;
  logic [8*PM-1:0]     pattern_aligned;
  logic [PM-1:0]       lane_ok;
  logic                sat;
  logic                hit;
  logic [PB-1:0]       start_full;

  // execute stage register
  logic                p_valid;
  logic                p_hit;
  logic                p_restart;
  logic [RB-1:0]       p_start;
  logic                p_sat;
  logic                p_adv;

  logic [RB-1:0]       match_counter;
  logic                is_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LB'(1);
    end else if (cfg_we) begin
      pattern_length <= cfg_data;
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_act = LB'(1);
    end else if (pattern_length > LB'(PM)) begin
      len_act = LB'(PM);
    end else begin
      len_act = pattern_length;
    end
  end

  // pattern reversed then shifted so byte j lines up with window byte j
  always_comb begin
    for (int i = 0; i < PM; i++) begin
      pattern_rev[8*i +: 8] = pattern[PM-1-i];
    end
    shift_amt       = LB'(PM) - len_act;
    pattern_aligned = pattern_rev >> {shift_amt, 3'b000};
  end

  always_comb begin
    window_next[0] = head.item.byte_value;
    for (int i = 1; i < PM; i++) begin
      window_next[i] = window[i-1];
    end
    for (int j = 0; j < PM; j++) begin
      lane_ok[j] = (window_next[j] == pattern_aligned[8*j +: 8]) | (LB'(j) >= len_act);
    end
  end

  always_comb begin
    sat           = (position == {PB{1'b1}});
    position_next = sat ? position : position + 1'b1;
    start_full    = position - PB'(len_act) + 1'b1;
    is_text       = (head.item.kind == npm_pkg::KIND_TEXT);
    hit           = is_text & (&lane_ok) & (position_next >= PB'(len_act));
  end

  assign p_adv = p_valid & (~p_hit | ~m_tvalid | m_tready);
  assign pop   = head.valid & (~p_valid | p_adv);

  always_ff @(posedge clk) begin
    if (pop && head.item.kind == npm_pkg::KIND_PATTERN) begin
      pattern[head.item.pattern_index] <= head.item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PM; i++) begin
        window[i] <= '0;
      end
      position <= '0;
    end else if (pop) begin
      unique case (head.item.kind)
        npm_pkg::KIND_TEXT: begin
          window   <= window_next;
          position <= position_next;
        end
        npm_pkg::KIND_RESTART: begin
          position <= '0;
        end
        default: begin
          position <= position;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      p_hit     <= 1'b0;
      p_restart <= 1'b0;
    end else if (pop) begin
      p_valid   <= 1'b1;
      p_hit     <= hit;
      p_restart <= (head.item.kind == npm_pkg::KIND_RESTART);
    end else if (p_adv) begin
      p_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_start <= RB'(start_full);
      p_sat   <= sat;
    end
  end

  // result stage: match count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (p_adv && p_restart) begin
        match_counter <= '0;
      end else if (p_adv && p_hit) begin
        match_counter <= match_counter + 1'b1;
      end
      if (p_adv && p_hit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv && p_hit) begin
      m_tdata <= {match_counter, p_start};
      m_tuser <= p_sat;
    end
  end

endmodule

// ===== design/naive_pattern_match_stream_top.sv =====
// top level of the naive pattern match stream block
// depends on npm_pkg, npm_front, npm_queue, npm_back
//
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata: byte_value, pattern_index; tuser: op
// m_*       out        m_tvalid/m_tready   tdata: match_start, match_number; tuser: saturated
// cfg_*     in         cfg_we              cfg_data: pattern_length
//
// one request per cycle in steady state while the output is not stalled; a matching text
// byte reaches m_tvalid through the queue entry, the compare stage and the output register
// the window compare runs over all 32 byte lanes combinationally, which sets the path
// reset is synchronous; pattern store is not cleared and needs writing before use
// a stalled output blocks a match and all requests after it; the four-entry queue buffers them
module naive_pattern_match_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value [7:0], pattern_index [12:8]
  input  logic [1:0]  s_tuser,   // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // match_start [31:0], match_number [63:32]
  output logic [0:0]  m_tuser,   // position_saturated [0]
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data
);

  logic                 push;
  npm_pkg::item_t       push_item;
  logic                 queue_full;
  logic                 pop;
  npm_pkg::queue_out_t  head;

  npm_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  npm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  npm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
